/* rtl/core/assert_macros.svh */
// assertion macros used by the top level of the echo delay line
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/fedl_pkg.sv */
// shared constants and types of the feedback echo delay line
// no dependencies; imported by every module of the block
`default_nettype none

package fedl_pkg;

   localparam int STORE_SAMPLES = 65536;
   localparam int ADDR_W        = $clog2(STORE_SAMPLES);
   localparam int COUNT_W       = ADDR_W + 1;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam int SAMPLE_W      = 16;
   localparam int FRAMES_W      = 16;
   localparam int FB_W          = 8;
   localparam int CH_W          = 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [FB_W-1:0]            FB_UNITY   = 8'd128;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELAY_FRAMES    = 2'd0,
      CSR_FEEDBACK_FACTOR = 2'd1,
      CSR_CHANNEL_COUNT   = 2'd2
   } csr_index_type;

   // one classified sample on its way from the front to the back
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] live;
      logic                       bypass;
      logic                       hit;
      logic [ADDR_W-1:0]          idx;
      logic [FB_W-1:0]            fb;
   } queue_entry_type;

endpackage

`default_nettype wire

/* rtl/core/fedl_front.sv */
// front of the echo delay line: config registers, block classification, store pointer
// depends on fedl_pkg; feeds fedl_queue
`default_nettype none

module fedl_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fedl_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                 req_block_start,
   input  logic [fedl_pkg::FRAMES_W-1:0]        req_block_frames,
   input  logic                                 csr_write_enable,
   input  logic [fedl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fedl_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 queue_full,
   output logic                                 push,
   output fedl_pkg::queue_entry_type            push_entry
);
   import fedl_pkg::*;

   localparam int WIDE_W = (COUNT_W > FRAMES_W + 1) ? COUNT_W : FRAMES_W + 1;

   localparam logic [FRAMES_W-1:0] DELAY_RESET = 16'd32768;
   localparam logic [FB_W-1:0]     FB_RESET    = 8'd64;
   localparam logic [CH_W-1:0]     CH_RESET    = 2'd2;

   logic [FRAMES_W-1:0] delay_ff;
   logic [FB_W-1:0]     fb_ff;
   logic [CH_W-1:0]     ch_ff;
   logic                bypass_ff;
   logic                bypass_in;
   logic [ADDR_W-1:0]   ptr_ff;
   logic [ADDR_W-1:0]   ptr_in;
   logic [COUNT_W-1:0]  fill_ff;

   logic                accept;
   logic                clear_store;
   logic                stereo;
   logic [FRAMES_W-1:0] delay_eff;
   logic [FB_W-1:0]     fb_eff;
   logic [WIDE_W-1:0]   raw_len;
   logic [COUNT_W-1:0]  region;
   logic [ADDR_W-1:0]   pos;
   logic [WIDE_W:0]     pos_end;
   logic                overrun;
   logic [ADDR_W-1:0]   ptr_start;
   logic [ADDR_W-1:0]   idx;
   logic [COUNT_W-1:0]  idx_next;
   logic                hit;
   logic                grow;

   assign req_stall   = queue_full;
   assign accept      = req_valid & ~queue_full;
   assign push        = accept;
   assign clear_store = csr_write_enable &&
                        (csr_index_type'(csr_index) == CSR_DELAY_FRAMES);

   always_comb begin
      stereo    = ch_ff[1];
      delay_eff = (delay_ff == '0) ? FRAMES_W'(1) : delay_ff;
      fb_eff    = (fb_ff > FB_UNITY) ? FB_UNITY : fb_ff;
      raw_len   = WIDE_W'(delay_eff) << stereo;
      region    = (raw_len > WIDE_W'(STORE_SAMPLES)) ? COUNT_W'(STORE_SAMPLES)
                                                     : COUNT_W'(raw_len);
      pos       = ptr_ff >> stereo;
      pos_end   = (WIDE_W + 1)'(pos) + (WIDE_W + 1)'(req_block_frames);
      overrun   = pos_end > (WIDE_W + 1)'(delay_eff);

      // bypass is decided only on the first sample of a block
      if (req_block_start) begin
         bypass_in = (fb_eff == '0) || (req_block_frames > delay_eff);
      end else begin
         bypass_in = bypass_ff;
      end

      ptr_start = (req_block_start && !bypass_in && overrun) ? '0 : ptr_ff;
      idx       = ({1'b0, ptr_start} >= region) ? '0 : ptr_start;
      idx_next  = {1'b0, idx} + COUNT_W'(1);
      ptr_in    = (idx_next >= region) ? '0 : idx_next[ADDR_W-1:0];

      // entries at or above the fill count were never written and read as zero
      hit  = {1'b0, idx} < fill_ff;
      grow = {1'b0, idx} == fill_ff;

      push_entry.live   = req_sample_in;
      push_entry.bypass = bypass_in;
      push_entry.hit    = hit;
      push_entry.idx    = idx;
      push_entry.fb     = fb_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= DELAY_RESET;
         fb_ff     <= FB_RESET;
         ch_ff     <= CH_RESET;
         bypass_ff <= 1'b0;
         ptr_ff    <= '0;
         fill_ff   <= '0;
      end else begin
         if (accept) begin
            bypass_ff <= bypass_in;
         end
         // a delay write empties the store and restarts the position
         if (clear_store) begin
            ptr_ff  <= '0;
            fill_ff <= '0;
         end else if (accept && !bypass_in) begin
            ptr_ff <= ptr_in;
            if (grow) begin
               fill_ff <= fill_ff + COUNT_W'(1);
            end
         end
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_DELAY_FRAMES: begin
                  delay_ff <= csr_write_data[FRAMES_W-1:0];
               end
               CSR_FEEDBACK_FACTOR: begin
                  fb_ff <= csr_write_data[FB_W-1:0];
               end
               CSR_CHANNEL_COUNT: begin
                  ch_ff <= csr_write_data[CH_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/fedl_queue.sv */
// short register queue between the front and the back of the echo delay line
// depends on fedl_pkg for the entry type and depth
`default_nettype none

module fedl_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  fedl_pkg::queue_entry_type push_entry,
   input  logic                      pop,
   output logic                      q_valid,
   output fedl_pkg::queue_entry_type q_entry,
   output logic                      q_full
);
   import fedl_pkg::*;

   queue_entry_type   entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      next_ptr = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
   endfunction

   assign q_valid = count_ff != '0;
   assign q_full  = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign q_entry = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (QPTR_W + 1)'(1);
            2'b01:   count_ff <= count_ff - (QPTR_W + 1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/core/fedl_back.sv */
// back of the echo delay line: delay store, feedback mix, output register
// depends on fedl_pkg; drains fedl_queue
`default_nettype none

module fedl_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  fedl_pkg::queue_entry_type            q_entry,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fedl_pkg::SAMPLE_W-1:0] rsp_sample_out
);
   import fedl_pkg::*;

   logic [SAMPLE_W-1:0]        store_mem [STORE_SAMPLES];

   logic                       m_valid_ff;
   queue_entry_type            m_entry_ff;
   logic [SAMPLE_W-1:0]        m_rdata_ff;
   logic                       m_fwd_ff;
   logic [SAMPLE_W-1:0]        m_fwd_data_ff;
   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_data_ff;

   logic                       advance;
   logic                       m_write;
   logic signed [SAMPLE_W-1:0] stored;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [FB_W:0]       fb_s;
   logic signed [25:0]         prod;
   logic signed [26:0]         sum;
   logic signed [26:0]         rounded;
   logic signed [19:0]         quot;
   logic                       pos_ovf;
   logic                       neg_ovf;
   logic [SAMPLE_W-1:0]        mix;

   // the whole back moves as one when the output register can take a value
   assign advance = ~out_valid_ff | ~rsp_stall;
   assign q_pop   = advance & q_valid;
   assign m_write = advance & m_valid_ff & ~m_entry_ff.bypass;

   always_comb begin
      if (m_fwd_ff) begin
         stored = m_fwd_data_ff;
      end else if (m_entry_ff.hit) begin
         stored = m_rdata_ff;
      end else begin
         stored = '0;
      end

      // stored*fb + live*(128-fb) == live*128 + (stored-live)*fb
      diff    = {stored[SAMPLE_W-1], stored} - {m_entry_ff.live[SAMPLE_W-1], m_entry_ff.live};
      fb_s    = {1'b0, m_entry_ff.fb};
      prod    = 26'(diff) * 26'(fb_s);
      sum     = {prod[25], prod} + {{4{m_entry_ff.live[SAMPLE_W-1]}}, m_entry_ff.live, 7'b0};
      // truncate toward zero
      rounded = sum[26] ? sum + 27'sd127 : sum;
      quot    = rounded[26:7];
      pos_ovf = ~quot[19] & (|quot[18:15]);
      neg_ovf = quot[19] & ~(&quot[18:15]);
      if (pos_ovf) begin
         mix = SAMPLE_MAX;
      end else if (neg_ovf) begin
         mix = SAMPLE_MIN;
      end else begin
         mix = quot[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (m_write) begin
         store_mem[m_entry_ff.idx] <= mix;
      end
      if (q_pop) begin
         m_rdata_ff <= store_mem[q_entry.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff   <= q_valid;
         out_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= m_entry_ff.bypass ? m_entry_ff.live : stored;
         if (q_valid) begin
            m_entry_ff    <= q_entry;
            // the read at this edge misses the write landing at the same edge
            m_fwd_ff      <= m_write && (m_entry_ff.idx == q_entry.idx);
            m_fwd_data_ff <= mix;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_data_ff;

endmodule

`default_nettype wire

/* rtl/core/feedback_echo_delay_line.sv */
// top level of the feedback echo delay line
// depends on fedl_pkg, fedl_front, fedl_queue, fedl_back and assert_macros.svh
//
// usage:
//  - req_ channel carries one interleaved audio sample per transaction, with
//    block_start / block_frames marking the first sample of a processing block
//  - rsp_ channel returns exactly one sample per request transaction, in order:
//    the delayed stored sample, or the live sample while the block bypasses
//  - csr_ port writes delay_frames (0), feedback_factor (1), channel_count (2);
//    write only while idle; writing delay_frames clears store and position
//  - an accepted transaction passes the queue, the store read register and the
//    output register, in that order, before it shows on rsp_valid
//  - throughput: one transaction per cycle sustained while rsp_stall is low; the
//    store does one read and one write per cycle; a forward covers back-to-back hits
//  - rsp_stall freezes the back part; the four-entry queue keeps taking
//    requests until it fills, then req_stall rises
//  - reset is synchronous, active high; the store reads as silence after reset
//    through a fill count, so there is no clearing pass and no start-up delay
`default_nettype none
`include "assert_macros.svh"

module feedback_echo_delay_line (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fedl_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                 req_block_start,
   input  logic [fedl_pkg::FRAMES_W-1:0]        req_block_frames,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fedl_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                 csr_write_enable,
   input  logic [fedl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fedl_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import fedl_pkg::*;

   // front -> queue
   logic            push;
   queue_entry_type push_entry;
   logic            q_full;

   // queue -> back
   logic            q_valid;
   queue_entry_type q_entry;
   logic            q_pop;

   // classification, register file and store pointer with its fill count
   fedl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .req_block_start  (req_block_start),
      .req_block_frames (req_block_frames),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (q_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // decouples the request side from output stalls
   fedl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_full     (q_full)
   );

   // delay store read-modify-write, mix and output register
   fedl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

   // the back never drains an empty queue
   `ASSERT_IMPL(a_pop_needs_entry, clock, reset, q_pop, q_valid, "pop from empty queue")

   // an accepted request is waiting in the queue in the next cycle
   `ASSERT_NEXT(a_push_visible, clock, reset, req_valid && !req_stall, q_valid, "accepted transaction lost before queue")

   // a fresh response always traces back to a pop, through the store read and output registers
   `ASSERT_IMPL(a_rsp_from_pop, clock, reset, $rose(rsp_valid), $past(q_pop, 2), "response without matching pop")

endmodule

`default_nettype wire
